>>> sv/ttcw_pkg.sv
`timescale 1ns / 1ps

package ttcw_pkg;

  // Command codes on the request channel
  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  // Result kinds on the response channel
  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SSTHRESH = 1'b1;
  localparam int unsigned CFG_DATA_W = 16;

  // Field widths
  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned WINOUT_W = 7;

  // Reset values of the configuration registers
  localparam logic [SEQ_W-1:0]    TOTAL_PACKETS_RST    = 16'd50;
  localparam logic [WINOUT_W-1:0] INITIAL_SSTHRESH_RST = 7'd8;

  // A send round emits at most this many packets
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned REM_W      = 7;

  // Duplicate acknowledgement counter
  localparam logic [2:0] DUP_TRIGGER = 3'd3;
  localparam logic [2:0] DUP_MAX     = 3'd4;

  typedef struct packed {
    logic             cmd;
    logic [SEQ_W-1:0] ack_seq;
  } req_item_t;

  typedef struct packed {
    logic                kind;
    logic [SEQ_W-1:0]    seq_num;
    logic                is_resend;
    logic [WINOUT_W-1:0] window;
    logic [WINOUT_W-1:0] threshold;
    logic                triple_dup;
    logic                loss_flag;
    logic                all_sent;
    logic                last;
  } rsp_item_t;

  typedef enum logic {
    OP_SEND,
    OP_ACK
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SEQ_W-1:0] ack_seq;
  } cmd_entry_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [SEQ_W-1:0] ack_seq;
  } queue_head_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    total_packets;
    logic [WINOUT_W-1:0] initial_ssthresh;
  } cfg_t;

endpackage

>>> sv/ttcw_stream_if.sv
`timescale 1ns / 1ps

interface ttcw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/ttcw_front.sv
`timescale 1ns / 1ps

module ttcw_front
  import ttcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ttcw_stream_if.sink req,
  output queue_head_t head,
  input  logic        pop
);

  cmd_entry_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  cmd_entry_t entry;

  // Accept while the queue has room
  assign req.ready = (cnt != 2'd2);
  assign push      = req.valid && req.ready;

  // Classify the incoming command
  always_comb begin
    entry.op      = (req.data.cmd == CMD_ACK) ? OP_ACK : OP_SEND;
    entry.ack_seq = req.data.ack_seq;
  end

  // Present the oldest entry
  assign head.valid   = (cnt != 2'd0);
  assign head.op      = q[rd_ptr].op;
  assign head.ack_seq = q[rd_ptr].ack_seq;

  // Store the entry on a transfer
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> sv/ttcw_back.sv
`timescale 1ns / 1ps

module ttcw_back
  import ttcw_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  queue_head_t   head,
  output logic          pop,
  ttcw_stream_if.source rsp
);

  localparam int unsigned WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TH_W  = (WIN_W > WINOUT_W) ? WIN_W : WINOUT_W;
  localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(1);

  typedef enum logic {
    S_IDLE,
    S_SEND
  } state_t;

  state_t             state, state_next;
  logic [WIN_W-1:0]   cwnd, cwnd_next;
  logic [WIN_W-1:0]   ssthresh, ssthresh_next;
  logic               ssthresh_set, ssthresh_set_next;
  logic [SEQ_W-1:0]   sent_count, sent_count_next;
  logic               loss_pending, loss_pending_next;
  logic [SEQ_W-1:0]   loss_seq, loss_seq_next;
  logic [SEQ_W-1:0]   prev_ack, prev_ack_next;
  logic               prev_valid, prev_valid_next;
  logic [2:0]         dup_count, dup_count_next;
  logic [WIN_W-1:0]   ack_count, ack_count_next;
  logic [REM_W-1:0]   rem, rem_next;
  logic               out_valid_next;
  rsp_item_t          out_next;

  logic               out_free;
  logic               load;
  logic [TH_W-1:0]    eff_cur;
  logic [TH_W-1:0]    eff_new;
  logic [TH_W-1:0]    cwnd_ext;
  logic [REM_W-1:0]   rem_start;
  logic               ack_match;
  logic [2:0]         dup_upd;
  logic               trip;
  logic [WIN_W-1:0]   ack_inc;
  logic               done;
  logic [WIN_W:0]     grow;
  logic [SEQ_W-1:0]   sent_after;

  assign out_free  = !rsp.valid || rsp.ready;
  assign eff_cur   = ssthresh_set ? TH_W'(ssthresh) : TH_W'(cfg.initial_ssthresh);
  assign cwnd_ext  = TH_W'(cwnd);
  assign rem_start = (cwnd_ext > TH_W'(RESULT_CAP)) ? REM_W'(RESULT_CAP) : REM_W'(cwnd_ext);

  // Sequence commands and compute the next window state
  always_comb begin
    state_next        = state;
    cwnd_next         = cwnd;
    ssthresh_next     = ssthresh;
    ssthresh_set_next = ssthresh_set;
    sent_count_next   = sent_count;
    loss_pending_next = loss_pending;
    loss_seq_next     = loss_seq;
    prev_ack_next     = prev_ack;
    prev_valid_next   = prev_valid;
    dup_count_next    = dup_count;
    ack_count_next    = ack_count;
    rem_next          = rem;
    out_next          = rsp.data;
    load              = 1'b0;
    pop               = 1'b0;
    ack_match         = prev_valid && (prev_ack == head.ack_seq);
    dup_upd           = ack_match ? ((dup_count >= DUP_MAX) ? DUP_MAX : dup_count + 3'd1)
                                  : 3'd1;
    trip              = (dup_upd == DUP_TRIGGER);
    ack_inc           = ack_count + WIN_ONE;
    done              = (ack_inc >= cwnd);
    eff_new           = eff_cur;
    grow              = '0;
    sent_after        = sent_count;

    unique case (state)
      S_IDLE: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          if (head.op == OP_ACK) begin
            // Track duplicates; the third equal one marks a loss
            if (trip) begin
              ssthresh_next     = cwnd >> 1;
              ssthresh_set_next = 1'b1;
              loss_seq_next     = head.ack_seq;
              loss_pending_next = 1'b1;
            end
            eff_new = ssthresh_set_next ? TH_W'(ssthresh_next) : TH_W'(cfg.initial_ssthresh);
            if (done) begin
              // Apply the window rule at the end of the round
              if (dup_upd < DUP_TRIGGER) begin
                grow = (cwnd_ext >= eff_new) ? ({1'b0, cwnd} + (WIN_W+1)'(1))
                                             : {cwnd, 1'b0};
                cwnd_next = (grow > {1'b0, WIN_MAX}) ? WIN_MAX : grow[WIN_W-1:0];
                if ({1'b0, sent_count} != ({1'b0, head.ack_seq} + 17'd1)) begin
                  loss_seq_next     = head.ack_seq;
                  loss_pending_next = 1'b1;
                end
              end else begin
                cwnd_next = WIN_ONE;
              end
              ack_count_next  = '0;
              dup_count_next  = '0;
              prev_valid_next = 1'b0;
            end else begin
              ack_count_next  = ack_inc;
              dup_count_next  = dup_upd;
              prev_valid_next = 1'b1;
            end
            prev_ack_next       = head.ack_seq;
            load                = 1'b1;
            out_next.kind       = KIND_ACK;
            out_next.seq_num    = head.ack_seq;
            out_next.is_resend  = 1'b0;
            out_next.window     = WINOUT_W'(cwnd_next);
            out_next.threshold  = WINOUT_W'(eff_new);
            out_next.triple_dup = trip;
            out_next.loss_flag  = loss_pending_next;
            out_next.all_sent   = (sent_count >= cfg.total_packets);
            out_next.last       = done;
          end else if (loss_pending || (sent_count < cfg.total_packets)) begin
            // Start a send round; nothing to send drops the command
            rem_next   = rem_start;
            state_next = S_SEND;
          end
        end
      end
      S_SEND: begin
        if (out_free) begin
          // Emit the resend first, then new sequence numbers
          load = 1'b1;
          if (loss_pending) begin
            loss_pending_next  = 1'b0;
            out_next.seq_num   = loss_seq;
            out_next.is_resend = 1'b1;
          end else begin
            sent_after         = sent_count + 16'd1;
            sent_count_next    = sent_after;
            out_next.seq_num   = sent_count;
            out_next.is_resend = 1'b0;
          end
          rem_next            = rem - REM_W'(1);
          out_next.kind       = KIND_SEND;
          out_next.window     = WINOUT_W'(cwnd);
          out_next.threshold  = WINOUT_W'(eff_cur);
          out_next.triple_dup = 1'b0;
          out_next.loss_flag  = 1'b0;
          out_next.all_sent   = (sent_after >= cfg.total_packets);
          out_next.last       = (rem == REM_W'(1)) || (sent_after >= cfg.total_packets);
          if (out_next.last) begin
            state_next = S_IDLE;
          end
        end
      end
    endcase

    out_valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : rsp.valid);
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cwnd         <= WIN_ONE;
      ssthresh     <= '0;
      ssthresh_set <= 1'b0;
      sent_count   <= '0;
      loss_pending <= 1'b0;
      loss_seq     <= '0;
      prev_ack     <= '0;
      prev_valid   <= 1'b0;
      dup_count    <= '0;
      ack_count    <= '0;
      rem          <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      state        <= state_next;
      cwnd         <= cwnd_next;
      ssthresh     <= ssthresh_next;
      ssthresh_set <= ssthresh_set_next;
      sent_count   <= sent_count_next;
      loss_pending <= loss_pending_next;
      loss_seq     <= loss_seq_next;
      prev_ack     <= prev_ack_next;
      prev_valid   <= prev_valid_next;
      dup_count    <= dup_count_next;
      ack_count    <= ack_count_next;
      rem          <= rem_next;
      rsp.valid    <= out_valid_next;
    end
    if (load) begin
      rsp.data <= out_next;
    end
  end

  // Window stays within one and the maximum
  a_cwnd_range: assert property (@(posedge clk) disable iff (rst)
    (cwnd != '0) && (cwnd <= WIN_MAX))
    else $error("congestion window out of range");

  // An acknowledgement round always closes before reaching the window
  a_ack_count: assert property (@(posedge clk) disable iff (rst)
    ack_count < cwnd)
    else $error("acknowledgement count reached window");

  // A running send round has packets left to emit
  a_send_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |-> (rem != '0))
    else $error("send round with nothing left");

  // A triple duplicate always leaves a resend pending
  a_trip_loss: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.triple_dup) |-> rsp.data.loss_flag)
    else $error("triple duplicate without pending loss");

  // Sends never leave a loss pending
  a_send_noloss: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) && (rsp.data.kind == KIND_SEND) |-> !rsp.data.loss_flag)
    else $error("send result with pending loss");

endmodule

>>> sv/tcp_tahoe_congestion_window.sv
`timescale 1ns / 1ps

// Congestion window controller for a Tahoe-style sender. Commands enter on req:
// cmd 0 opens a send round, cmd 1 delivers one acknowledgement. A send round
// emits up to min(window, 64) packets, one per cycle while the output is free, a
// pending retransmission first, and stops early once the packet budget is used
// up; it emits nothing when there is neither a resend nor a new packet left. An
// acknowledgement yields one status result. Throughput is set by the single
// back-end sequencer that owns the window state and produces one result per
// cycle, when the one-deep output register is free; a two-entry command queue
// in front keeps accepting while it has room. The user must write registers
// total_packets (index 0) and initial_ssthresh (index 1) through
// cfg_we/cfg_idx/cfg_wdata only while the block is idle; it does not enforce this.

module tcp_tahoe_congestion_window
  import ttcw_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ttcw_stream_if.sink           req,
  ttcw_stream_if.source         rsp
);

  cfg_t        cfg;
  queue_head_t head;
  logic        pop;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_packets    <= TOTAL_PACKETS_RST;
      cfg.initial_ssthresh <= INITIAL_SSTHRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TOTAL_PACKETS:    cfg.total_packets    <= cfg_wdata[SEQ_W-1:0];
        REG_INITIAL_SSTHRESH: cfg.initial_ssthresh <= cfg_wdata[WINOUT_W-1:0];
        default:              cfg                  <= cfg;
      endcase
    end
  end

  ttcw_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  ttcw_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

>>> tb/tcp_tahoe_congestion_window_tb.sv
`timescale 1ns / 1ps

module tcp_tahoe_congestion_window_tb;
  import ttcw_pkg::*;

  localparam int unsigned WIN_LIMIT = 64;

  typedef enum int {
    ROUND_CLEAN,
    ROUND_TRIPLE,
    ROUND_LOSSY,
    ROUND_NOISE
  } round_t;

  // Window predictor and queue of expected send and ack results
  class tahoe_scoreboard;
    logic [SEQ_W-1:0]    total;
    logic [WINOUT_W-1:0] init_thresh;
    int unsigned cwnd;
    int unsigned thresh_reg;
    bit          thresh_set;
    int unsigned sent;
    bit          loss_pend;
    int unsigned loss_at;
    int unsigned last_ack;
    bit          last_ok;
    int unsigned dups;
    int unsigned acks;
    rsp_item_t   expected[$];
    int unsigned mismatches;
    int unsigned commands;
    int unsigned results;
    int unsigned resends;
    int unsigned trips;
    int unsigned peak;

    function new();
      total       = TOTAL_PACKETS_RST;
      init_thresh = INITIAL_SSTHRESH_RST;
      cwnd        = 1;
      peak        = 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_TOTAL_PACKETS) begin
        total = value;
      end else begin
        init_thresh = value[WINOUT_W-1:0];
      end
    endfunction

    function int unsigned threshold_now();
      return thresh_set ? thresh_reg : int'(init_thresh);
    endfunction

    function void push(logic kind, logic [SEQ_W-1:0] seq, logic resend, logic trip,
                       logic fin);
      rsp_item_t r;
      r.kind       = kind;
      r.seq_num    = seq;
      r.is_resend  = resend;
      r.window     = cwnd[WINOUT_W-1:0];
      r.threshold  = WINOUT_W'(threshold_now());
      r.triple_dup = trip;
      r.loss_flag  = loss_pend;
      r.all_sent   = (sent >= total);
      r.last       = fin;
      expected.push_back(r);
    endfunction

    // Advance the window state by one accepted command
    function void note(logic cmd, logic [SEQ_W-1:0] ack);
      int unsigned n;
      int unsigned seq;
      int unsigned a;
      logic trip;
      logic fin;
      commands++;
      a = 32'(ack);
      if (cmd == CMD_SEND) begin
        n = 0;
        for (int unsigned i = 0; i < cwnd && n < RESULT_CAP; i++) begin
          if (loss_pend) begin
            loss_pend = 1'b0;
            push(KIND_SEND, loss_at[SEQ_W-1:0], 1'b1, 1'b0, 1'b0);
            resends++;
            n++;
          end else if (sent < total) begin
            seq  = sent;
            sent = (sent + 1) & 32'hFFFF;
            push(KIND_SEND, seq[SEQ_W-1:0], 1'b0, 1'b0, 1'b0);
            n++;
          end else begin
            break;
          end
        end
        if (n > 0) expected[expected.size()-1].last = 1'b1;
      end else begin
        trip = 1'b0;
        fin  = 1'b0;
        if (last_ok && last_ack == a) begin
          if (dups < DUP_MAX) dups++;
        end else begin
          dups = 1;
        end
        // Third equal ack in a row: halve the threshold and mark the loss
        if (dups == DUP_TRIGGER) begin
          thresh_reg = cwnd / 2;
          thresh_set = 1'b1;
          loss_at    = a;
          loss_pend  = 1'b1;
          trip       = 1'b1;
          trips++;
        end
        last_ack = a;
        last_ok  = 1'b1;
        acks++;
        // End of ack round: apply the window rule
        if (acks >= cwnd) begin
          if (dups < DUP_TRIGGER) begin
            if (cwnd >= threshold_now()) cwnd = cwnd + 1;
            else cwnd = cwnd * 2;
            if (cwnd > WIN_LIMIT) cwnd = WIN_LIMIT;
            if (sent != a + 1) begin
              loss_at   = a;
              loss_pend = 1'b1;
            end
          end else begin
            cwnd = 1;
          end
          if (cwnd > peak) peak = cwnd;
          acks    = 0;
          dups    = 0;
          last_ok = 1'b0;
          fin     = 1'b1;
        end
        push(KIND_ACK, ack, 1'b0, trip, fin);
      end
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t ERROR %s: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check(rsp_item_t got);
      rsp_item_t want;
      results++;
      if (expected.size() == 0) begin
        mismatches++;
        $display("%0t ERROR unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = expected.pop_front();
      compare("kind", want.kind, got.kind);
      compare("seq_num", want.seq_num, got.seq_num);
      compare("is_resend", want.is_resend, got.is_resend);
      compare("window", want.window, got.window);
      compare("threshold", want.threshold, got.threshold);
      compare("triple_dup", want.triple_dup, got.triple_dup);
      compare("loss_flag", want.loss_flag, got.loss_flag);
      compare("all_sent", want.all_sent, got.all_sent);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ttcw_stream_if #(.payload_t(req_item_t)) req_ch ();
  ttcw_stream_if #(.payload_t(rsp_item_t)) rsp_ch ();

  tahoe_scoreboard sb = new();
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  tcp_tahoe_congestion_window #(.MAX_WINDOW(WIN_LIMIT)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check each result transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check(rsp_ch.data);
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one command and hold it until its transfer
  task automatic put_cmd(logic cmd, logic [SEQ_W-1:0] ack);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.data.cmd     <= cmd;
    req_ch.data.ack_seq <= ack;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note(cmd, ack);
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] total, logic [CFG_DATA_W-1:0] thresh);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_TOTAL_PACKETS;
    cfg_wdata <= total;
    @(posedge clk);
    sb.write_reg(REG_TOTAL_PACKETS, total);
    cfg_idx   <= REG_INITIAL_SSTHRESH;
    cfg_wdata <= thresh;
    @(posedge clk);
    sb.write_reg(REG_INITIAL_SSTHRESH, thresh);
    cfg_we    <= 1'b0;
  endtask

  // One ack round sized to the current window, with a stray send now and then
  task automatic ack_round(round_t shape, int unsigned stop);
    int unsigned n;
    int unsigned s;
    int unsigned base;
    int unsigned p;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] d;
    n    = sb.cwnd;
    s    = sb.sent;
    base = (s > n) ? s - n : 0;
    p    = (n >= 3) ? $urandom_range(n - 3, 0) : n;
    d    = (s > 0) ? SEQ_W'($urandom_range(s - 1, 0)) : '0;
    for (int unsigned k = 0; k < n && sb.commands < stop; k++) begin
      if ($urandom_range(99) < 4) put_cmd(CMD_SEND, SEQ_W'($urandom));
      case (shape)
        ROUND_CLEAN:  a = SEQ_W'((k == n - 1) ? s - 1 : base + k);
        ROUND_TRIPLE: a = (k >= p) ? d : SEQ_W'(base + k);
        ROUND_LOSSY:  a = SEQ_W'($urandom_range(s + 2, 0));
        default:      a = ($urandom_range(3) == 0) ?
                          ($urandom_range(1) ? 16'hFFFF : 16'h0000) : SEQ_W'($urandom);
      endcase
      put_cmd(CMD_ACK, a);
    end
  endtask

  // Send rounds each followed by an ack round, plus stray commands
  task automatic run_rounds(int unsigned target, int unsigned triple_pct);
    int unsigned stop;
    int unsigned r;
    stop = sb.commands + target;
    while (sb.commands < stop) begin
      r = $urandom_range(99);
      if (r < 6) begin
        put_cmd(1'($urandom_range(1)), SEQ_W'($urandom));
      end else begin
        put_cmd(CMD_SEND, SEQ_W'($urandom));
        r = $urandom_range(99);
        if (r < triple_pct) ack_round(ROUND_TRIPLE, stop);
        else if (r < 65) ack_round(ROUND_CLEAN, stop);
        else if (r < 88) ack_round(ROUND_LOSSY, stop);
        else ack_round(ROUND_NOISE, stop);
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_TOTAL_PACKETS;
    cfg_wdata     <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.data   <= '0;
    send_idle_pct = 19;
    recv_idle_pct = 64;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: ack before any send, resend of the top sequence, clean round,
    // four equal acks, a send inside an ack round
    put_cmd(CMD_ACK, 16'hFFFF);
    put_cmd(CMD_SEND, 16'hFFFF);
    put_cmd(CMD_ACK, 16'h0000);
    put_cmd(CMD_ACK, 16'h0000);
    put_cmd(CMD_SEND, 16'h0000);
    repeat (4) put_cmd(CMD_ACK, 16'd4);
    put_cmd(CMD_SEND, 16'h5555);
    put_cmd(CMD_ACK, 16'd4);
    put_cmd(CMD_ACK, 16'd4);
    put_cmd(CMD_SEND, 16'hAAAA);
    put_cmd(CMD_ACK, 16'd6);
    settle();

    // Short budget, top threshold: window ramps to the cap
    program_regs(16'd120, 16'd64);
    run_rounds(90, 5);
    settle();

    // Full budget, threshold of one
    send_idle_pct = 64;
    recv_idle_pct = 19;
    program_regs(16'hFFFF, 16'd1);
    run_rounds(90, 22);
    settle();

    // Out of range threshold, budget just above what was sent
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(CFG_DATA_W'(sb.sent + $urandom_range(400, 20)), 16'd127);
    run_rounds(90, 22);
    settle();

    // Nothing new to send and a zero threshold
    program_regs(16'd0, 16'd0);
    run_rounds(30, 22);
    settle();

    $display("Covered %0d commands and %0d results: %0d retransmissions, %0d triple dups",
             sb.commands, sb.results, sb.resends, sb.trips);
    $display("Peak window %0d over five register settings", sb.peak);
    if (sb.mismatches == 0 && sb.expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> tcp_tahoe_congestion_window.f
sv/ttcw_pkg.sv
sv/ttcw_stream_if.sv
sv/ttcw_front.sv
sv/ttcw_back.sv
sv/tcp_tahoe_congestion_window.sv
tb/tcp_tahoe_congestion_window_tb.sv
